// ===== design/efr_pkg.sv =====
// Shared types, widths and codes of the edge-function rasterizer with depth test.
package efr_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;
	localparam int DEPTH_BITS_DEF = 24;

	localparam int CW  = 16;      // pixel-space vertex coordinate, 4 fraction bits
	localparam int DW  = 17;      // coordinate difference
	localparam int EW  = 36;      // edge value / total area, signed
	localparam int MW  = 35;      // edge / area magnitude
	localparam int MA  = 26;      // multiplier operand a
	localparam int MB  = 19;      // multiplier operand b
	localparam int PW  = MA + MB; // product
	localparam int ACW = PW + 2;  // accumulator
	localparam int MANT_W = 25;
	localparam int EXP_W  = 6;
	localparam int QBITS  = 24;   // reciprocal quotient bits

	localparam logic [23:0] Z_TOP   = 24'hFFFFFE;
	localparam logic [23:0] Z_FAR24 = 24'hFFFFFF;
	localparam logic [16:0] W_ONE   = 17'd65536;

	typedef enum logic [1:0] {
		FUNC_LOAD  = 2'd0,
		FUNC_STEP  = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	localparam logic [1:0] CFG_DEPTH_MODE = 2'd0;
	localparam logic [1:0] CFG_WINDING    = 2'd1;
	localparam logic [1:0] CFG_SCREEN_W   = 2'd2;
	localparam logic [1:0] CFG_SCREEN_H   = 2'd3;

	localparam logic [2:0] ZCMP_NEVER  = 3'd0;
	localparam logic [2:0] ZCMP_LESS   = 3'd1;
	localparam logic [2:0] ZCMP_EQUAL  = 3'd2;
	localparam logic [2:0] ZCMP_LEQUAL = 3'd3;
	localparam logic [2:0] ZCMP_ALWAYS = 3'd4;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic [23:0]        az;
		logic signed [15:0] bx;
		logic signed [15:0] by_coord;
		logic [23:0]        bz;
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic [23:0]        cz;
	} req_t;

	typedef struct packed {
		logic [7:0]  pix_x;
		logic [7:0]  pix_y;
		logic [23:0] depth;
		logic [16:0] weight_a;
		logic [16:0] weight_b;
		logic [16:0] weight_c;
		logic        covered;
		logic        done_res;
	} rsp_t;

	typedef struct packed {
		logic          start;
		logic [MW-1:0] mag;
	} recip_cmd_t;

	typedef struct packed {
		logic              done;
		logic [MANT_W-1:0] mant;
		logic [EXP_W-1:0]  expo;
	} recip_res_t;

endpackage

// ===== design/efr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module efr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/efr_mul.sv =====
// Shared signed multiplier with registered product.
module efr_mul import efr_pkg::*; (
	input  logic                 clk,
	input  logic signed [MA-1:0] a,
	input  logic signed [MB-1:0] b,
	output logic signed [PW-1:0] p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

// ===== design/efr_recip.sv =====
// Iterative reciprocal of the triangle area: leading-one search, then restoring division.
module efr_recip import efr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  recip_cmd_t cmd,
	output recip_res_t res
);

	typedef enum logic [1:0] {R_IDLE, R_SEARCH, R_DIV} rstate_t;

	rstate_t          state_q;
	logic [MW-1:0]    a_q;
	logic [MW-1:0]    t_q;
	logic [MW:0]      rem_q;
	logic [QBITS-1:0] q_q;
	logic [EXP_W-1:0] e_q;
	logic [4:0]       bit_q;
	logic             done_q;

	logic          ge;
	logic [MW:0]   rem_n;

	always_comb begin
		ge    = rem_q >= {1'b0, a_q};
		rem_n = ge ? rem_q - {1'b0, a_q} : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: begin
					if (cmd.start) begin
						a_q     <= cmd.mag;
						t_q     <= cmd.mag;
						rem_q   <= (MW+1)'(1);
						e_q     <= '0;
						state_q <= R_SEARCH;
					end
				end
				R_SEARCH: begin
					// rem tracks 2^e while the magnitude is shifted down to one
					if (t_q[MW-1:1] != '0) begin
						t_q   <= t_q >> 1;
						rem_q <= rem_q << 1;
						e_q   <= e_q + EXP_W'(1);
					end else begin
						q_q     <= '0;
						bit_q   <= 5'(QBITS - 1);
						state_q <= R_DIV;
					end
				end
				R_DIV: begin
					q_q   <= {q_q[QBITS-2:0], ge};
					rem_q <= {rem_n[MW-1:0], 1'b0};
					if (bit_q == '0) begin
						done_q  <= 1'b1;
						state_q <= R_IDLE;
					end else begin
						bit_q <= bit_q - 5'd1;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	assign res.done = done_q;
	assign res.mant = MANT_W'(q_q);
	assign res.expo = e_q;

endmodule

// ===== design/edge_function_triangle_raster_ztest.sv =====
// Top level: triangle rasterizer with depth store, one shared multiplier under a sequencer.
//
// Usage. Items arrive on req (req_valid / req_ready); each item returns exactly one
// word on rsp (rsp_valid / rsp_ready). req.func selects load triangle, step one
// pixel, clear depth store; the unused code returns an all-zero word. Registers are
// written on cfg_we with cfg_index / cfg_data; the user must write them only while
// the block is idle, as the block does not enforce it. Timing. One item is worked
// at a time; req_ready is high only in the idle state. A step runs 7 multiplies for
// the edges and the store index, then for an inside pixel 6 for the weights and 3
// for depth, all through the single multiplier, then the depth compare and write.
// An empty-box step or an unused code goes straight to the output. A load maps the
// vertices, forms box and area, then for a non-empty box and non-zero area waits for
// the reciprocal unit: leading-one search, division, hand-back. A clear writes the
// far value to all MAX_WIDTH*MAX_HEIGHT store entries (65536 by default), one store
// entry per cycle; after arst_n the block does the same sweep and accepts no item
// meanwhile. Stall. A finished word waits in the output register; the next item is
// accepted while it waits, and that item's word holds until the register frees.
module edge_function_triangle_raster_ztest import efr_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data
);

	localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW  = $clog2(STORE_SIZE);
	localparam int ZW  = DEPTH_BITS + 24;
	localparam int SHL = (DEPTH_BITS >= 24) ? DEPTH_BITS - 24 : 0;
	localparam int SHR = (DEPTH_BITS < 24) ? 24 - DEPTH_BITS : 0;
	localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_SIZE - 1);
	localparam logic [DEPTH_BITS-1:0] FAR = '1;
	localparam logic [8:0] MAXW9 = (MAX_WIDTH > 511) ? 9'd511 : 9'(MAX_WIDTH);
	localparam logic [8:0] MAXH9 = (MAX_HEIGHT > 511) ? 9'd511 : 9'(MAX_HEIGHT);

	typedef enum logic [3:0] {
		S_IDLE, S_CLR, S_LMAP, S_LBOX, S_LAREA, S_LRECIP,
		S_EDGE, S_WGT, S_DEPTH, S_OUT
	} state_t;

	state_t                  state_q;
	logic [2:0]              cnt_q;
	logic [AW-1:0]           clr_addr_q;
	logic                    clr_report_q;
	req_t                    req_q;
	rsp_t                    pend_q;
	rsp_t                    rsp_q;
	logic                    rsp_valid_q;
	logic [2:0]              depth_mode_q;
	logic                    winding_q;
	logic [8:0]              scr_w_q;
	logic [8:0]              scr_h_q;
	logic signed [CW-1:0]    vx_q [3];
	logic signed [CW-1:0]    vy_q [3];
	logic [23:0]             vz_q [3];
	logic [8:0]              box_x0_q, box_x1_q, box_y0_q, box_y1_q;
	logic [8:0]              cur_x_q, cur_y_q;
	logic [8:0]              x_q, y_q;
	logic                    box_empty_q;
	logic                    lbad_q;
	logic [MANT_W-1:0]       m_q;
	logic [EXP_W-1:0]        e_q;
	logic signed [ACW-1:0]   acc_q;
	logic signed [EW-1:0]    ea_q, eb_q, ec_q;
	logic [AW-1:0]           idx_q;
	logic [DEPTH_BITS-1:0]   old_q;

	logic [8:0]              eff_w, eff_h;
	logic [1:0]              ksel;
	logic signed [CW-1:0]    in_x, in_y;
	logic signed [CW-1:0]    vix, viy, vjx, vjy;
	logic signed [DW-1:0]    pxs, pys, op_a, op_b;
	logic signed [EW-1:0]    esel;
	logic [MW-1:0]           emag;
	logic [23:0]             zsel;
	logic [16:0]             wsel;
	logic signed [MA-1:0]    mul_a;
	logic signed [MB-1:0]    mul_b;
	logic signed [PW-1:0]    mul_p;
	logic signed [ACW-1:0]   diff_c;
	logic signed [EW-1:0]    edge_c;
	logic [MW-1:0]           area_mag;
	logic                    inside_c;
	logic [PW-1:0]           idx_sum;
	logic [61:0]             wsum, wfull;
	logic [6:0]              wsh;
	logic [16:0]             wsat_c;
	logic signed [ACW-1:0]   zsum;
	logic [ACW-17:0]         zfull;
	logic [23:0]             zsat_c;
	logic [ZW-1:0]           zwide;
	logic [DEPTH_BITS-1:0]   zs_c;
	logic                    pass_c;
	logic signed [DW-1:0]    rx [3];
	logic signed [DW-1:0]    ry [3];
	logic signed [DW-1:0]    bx0, bx1, by0, by1;
	logic signed [CW-1:0]    map_c;
	recip_cmd_t              rcmd;
	recip_res_t              rres;
	logic                    ram_we, ram_re;
	logic [AW-1:0]           ram_waddr;
	logic [DEPTH_BITS-1:0]   ram_wdata, ram_rdata;
	rsp_t                    pend_init;
	logic                    out_load;

	always_comb begin
		eff_w = (scr_w_q < 9'd2) ? 9'd2 : ((scr_w_q > MAXW9) ? MAXW9 : scr_w_q);
		eff_h = (scr_h_q < 9'd2) ? 9'd2 : ((scr_h_q > MAXH9) ? MAXH9 : scr_h_q);
	end

	// first contents of the pending word when an item is taken
	always_comb begin
		pend_init = '0;
		if (req.func == FUNC_STEP) begin
			if (box_empty_q) begin
				pend_init.done_res = 1'b1;
			end else begin
				pend_init.pix_x    = cur_x_q[7:0];
				pend_init.pix_y    = cur_y_q[7:0];
				pend_init.done_res = !(cur_x_q < box_x1_q) && !(cur_y_q < box_y1_q);
			end
		end
		out_load = (state_q == S_OUT) && (!rsp_valid_q || rsp_ready);
	end

	// operand selection for the shared multiplier
	always_comb begin
		ksel = (state_q == S_DEPTH) ? cnt_q[1:0] : cnt_q[2:1];
		unique case (ksel)
			2'd0: begin in_x = req_q.ax; in_y = req_q.ay; end
			2'd1: begin in_x = req_q.bx; in_y = req_q.by_coord; end
			2'd2: begin in_x = req_q.cx; in_y = req_q.cy; end
			default: begin in_x = '0; in_y = '0; end
		endcase
		unique case (ksel)
			2'd0: begin
				vix = vx_q[1]; viy = vy_q[1]; vjx = vx_q[2]; vjy = vy_q[2];
				esel = ea_q; zsel = vz_q[0]; wsel = pend_q.weight_a;
			end
			2'd1: begin
				vix = vx_q[2]; viy = vy_q[2]; vjx = vx_q[0]; vjy = vy_q[0];
				esel = eb_q; zsel = vz_q[1]; wsel = pend_q.weight_b;
			end
			2'd2: begin
				vix = vx_q[0]; viy = vy_q[0]; vjx = vx_q[1]; vjy = vy_q[1];
				esel = ec_q; zsel = vz_q[2]; wsel = pend_q.weight_c;
			end
			default: begin
				vix = '0; viy = '0; vjx = '0; vjy = '0;
				esel = '0; zsel = '0; wsel = '0;
			end
		endcase
		emag = esel[EW-1] ? MW'(-esel) : MW'(esel);
		pxs  = $signed({4'b0, x_q, 4'b0});
		pys  = $signed({4'b0, y_q, 4'b0});
		op_a = '0;
		op_b = '0;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_LMAP: begin
				if (!cnt_q[0]) begin
					op_a  = DW'(in_x) + DW'(16384);
					mul_b = MB'({1'b0, eff_w});
				end else begin
					op_a  = DW'(16384) - DW'(in_y);
					mul_b = MB'({1'b0, eff_h});
				end
				mul_a = MA'(op_a);
			end
			S_LAREA: begin
				if (!cnt_q[0]) begin
					op_a = DW'(vx_q[0]) - DW'(vx_q[1]);
					op_b = DW'(vy_q[2]) - DW'(vy_q[1]);
				end else begin
					op_a = DW'(vy_q[0]) - DW'(vy_q[1]);
					op_b = DW'(vx_q[2]) - DW'(vx_q[1]);
				end
				mul_a = MA'(op_a);
				mul_b = MB'(op_b);
			end
			S_EDGE: begin
				if (cnt_q == 3'd6) begin
					mul_a = MA'({1'b0, y_q});
					mul_b = MB'({1'b0, eff_w});
				end else begin
					if (!cnt_q[0]) begin
						op_a = pxs - DW'(vix);
						op_b = DW'(vjy) - DW'(viy);
					end else begin
						op_a = pys - DW'(viy);
						op_b = DW'(vjx) - DW'(vix);
					end
					mul_a = MA'(op_a);
					mul_b = MB'(op_b);
				end
			end
			S_WGT: begin
				mul_a = MA'({1'b0, m_q});
				mul_b = cnt_q[0] ? MB'({1'b0, emag[MW-1:18]}) : MB'({1'b0, emag[17:0]});
			end
			S_DEPTH: begin
				mul_a = MA'({1'b0, zsel});
				mul_b = MB'({1'b0, wsel});
			end
			default: ;
		endcase
	end

	efr_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// consumers of the registered product
	always_comb begin
		diff_c   = acc_q - ACW'(mul_p);
		edge_c   = EW'(diff_c);
		area_mag = edge_c[EW-1] ? MW'(-edge_c) : MW'(edge_c);
		if (winding_q) begin
			inside_c = !ea_q[EW-1] && !eb_q[EW-1] && !ec_q[EW-1];
		end else begin
			inside_c = (ea_q[EW-1] || ea_q == '0) && (eb_q[EW-1] || eb_q == '0)
				&& (ec_q[EW-1] || ec_q == '0);
		end
		idx_sum = mul_p[PW-1:0] + PW'(x_q);
		map_c   = CW'(mul_p >>> 11);
		wsum    = 62'(acc_q[PW-1:0]) + (62'(mul_p[PW-1:0]) << 18);
		wsh     = 7'd7 + 7'(e_q);
		wfull   = wsum >> wsh;
		wsat_c  = (wfull > 62'(W_ONE)) ? W_ONE : wfull[16:0];
		zsum    = acc_q + ACW'(mul_p) + ACW'(32768);
		zfull   = zsum[ACW-1:16];
		zsat_c  = (zfull > (ACW-16)'(Z_TOP)) ? Z_TOP : zfull[23:0];
		zwide   = (ZW'(pend_q.depth) << SHL) >> SHR;
		zs_c    = (zwide[DEPTH_BITS-1:0] == FAR) ? FAR - 1'b1 : zwide[DEPTH_BITS-1:0];
		unique case (depth_mode_q)
			ZCMP_LESS:   pass_c = zs_c < old_q;
			ZCMP_EQUAL:  pass_c = zs_c == old_q;
			ZCMP_LEQUAL: pass_c = zs_c <= old_q;
			ZCMP_ALWAYS: pass_c = 1'b1;
			default:     pass_c = 1'b0;
		endcase
	end

	// bounding box from rounded vertices
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rx[i] = (DW'(vx_q[i]) + DW'(8)) >>> 4;
			ry[i] = (DW'(vy_q[i]) + DW'(8)) >>> 4;
		end
		bx0 = rx[0]; bx1 = rx[0]; by0 = ry[0]; by1 = ry[0];
		for (int i = 1; i < 3; i++) begin
			if (rx[i] < bx0) bx0 = rx[i];
			if (rx[i] > bx1) bx1 = rx[i];
			if (ry[i] < by0) by0 = ry[i];
			if (ry[i] > by1) by1 = ry[i];
		end
		if (bx0 < DW'(1)) bx0 = DW'(1);
		if (by0 < DW'(1)) by0 = DW'(1);
		if (bx1 > $signed({8'b0, eff_w}) - DW'(1)) bx1 = $signed({8'b0, eff_w}) - DW'(1);
		if (by1 > $signed({8'b0, eff_h}) - DW'(1)) by1 = $signed({8'b0, eff_h}) - DW'(1);
	end

	always_comb begin
		rcmd.start = (state_q == S_LAREA) && (cnt_q == 3'd2) && !lbad_q && (edge_c != '0);
		rcmd.mag   = area_mag;
	end

	efr_recip u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (rcmd),
		.res    (rres)
	);

	always_comb begin
		ram_we    = (state_q == S_CLR) || (state_q == S_DEPTH && cnt_q == 3'd4 && pass_c);
		ram_waddr = (state_q == S_CLR) ? clr_addr_q : idx_q;
		ram_wdata = (state_q == S_CLR) ? FAR : zs_c;
		ram_re    = (state_q == S_WGT) && (cnt_q == 3'd0);
	end

	efr_ram #(
		.WIDTH (DEPTH_BITS),
		.DEPTH (STORE_SIZE)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			cnt_q        <= '0;
			clr_addr_q   <= '0;
			clr_report_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
			depth_mode_q <= ZCMP_LESS;
			winding_q    <= 1'b0;
			scr_w_q      <= 9'd256;
			scr_h_q      <= 9'd256;
			box_empty_q  <= 1'b1;
			box_x0_q     <= '0;
			box_x1_q     <= '0;
			box_y0_q     <= '0;
			box_y1_q     <= '0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DEPTH_MODE: depth_mode_q <= cfg_data[2:0];
					CFG_WINDING:    winding_q    <= cfg_data[0];
					CFG_SCREEN_W:   scr_w_q      <= cfg_data;
					CFG_SCREEN_H:   scr_h_q      <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cnt_q  <= '0;
						req_q  <= req;
						pend_q <= pend_init;
						unique case (func_t'(req.func))
							FUNC_LOAD: state_q <= S_LMAP;
							FUNC_STEP: begin
								if (box_empty_q) begin
									state_q <= S_OUT;
								end else begin
									x_q <= cur_x_q;
									y_q <= cur_y_q;
									// advance in row order; the last pixel empties the box
									if (cur_x_q < box_x1_q) begin
										cur_x_q <= cur_x_q + 9'd1;
									end else begin
										cur_x_q <= box_x0_q;
										if (cur_y_q < box_y1_q) begin
											cur_y_q <= cur_y_q + 9'd1;
										end else begin
											box_empty_q <= 1'b1;
										end
									end
									state_q <= S_EDGE;
								end
							end
							FUNC_CLEAR: begin
								clr_addr_q   <= '0;
								clr_report_q <= 1'b1;
								state_q      <= S_CLR;
							end
							FUNC_NOP: state_q <= S_OUT;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_CLR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == LAST_ADDR) begin
						pend_q.done_res <= clr_report_q;
						state_q <= clr_report_q ? S_OUT : S_IDLE;
					end
				end
				S_LMAP: begin
					cnt_q <= (cnt_q == 3'd6) ? 3'd0 : cnt_q + 3'd1;
					unique case (cnt_q)
						3'd1: vx_q[0] <= map_c;
						3'd2: vy_q[0] <= map_c;
						3'd3: vx_q[1] <= map_c;
						3'd4: vy_q[1] <= map_c;
						3'd5: vx_q[2] <= map_c;
						3'd6: begin
							vy_q[2] <= map_c;
							state_q <= S_LBOX;
						end
						default: ;
					endcase
				end
				S_LBOX: begin
					vz_q[0]  <= (req_q.az == Z_FAR24) ? Z_TOP : req_q.az;
					vz_q[1]  <= (req_q.bz == Z_FAR24) ? Z_TOP : req_q.bz;
					vz_q[2]  <= (req_q.cz == Z_FAR24) ? Z_TOP : req_q.cz;
					box_x0_q <= bx0[8:0];
					box_x1_q <= bx1[8:0];
					box_y0_q <= by0[8:0];
					box_y1_q <= by1[8:0];
					cur_x_q  <= bx0[8:0];
					cur_y_q  <= by0[8:0];
					lbad_q   <= (bx0 > bx1) || (by0 > by1);
					cnt_q    <= '0;
					state_q  <= S_LAREA;
				end
				S_LAREA: begin
					cnt_q <= (cnt_q == 3'd2) ? 3'd0 : cnt_q + 3'd1;
					if (cnt_q == 3'd1) begin
						acc_q <= ACW'(mul_p);
					end else if (cnt_q == 3'd2) begin
						if (lbad_q || edge_c == '0) begin
							box_empty_q     <= 1'b1;
							pend_q.done_res <= 1'b1;
							state_q         <= S_OUT;
						end else begin
							state_q <= S_LRECIP;
						end
					end
				end
				S_LRECIP: begin
					if (rres.done) begin
						m_q         <= rres.mant;
						e_q         <= rres.expo;
						box_empty_q <= 1'b0;
						state_q     <= S_OUT;
					end
				end
				S_EDGE: begin
					// the count wraps to zero after the index cycle
					cnt_q <= cnt_q + 3'd1;
					unique case (cnt_q)
						3'd1, 3'd3, 3'd5: acc_q <= ACW'(mul_p);
						3'd2: ea_q <= edge_c;
						3'd4: eb_q <= edge_c;
						3'd6: ec_q <= edge_c;
						3'd7: begin
							idx_q   <= idx_sum[AW-1:0];
							state_q <= inside_c ? S_WGT : S_OUT;
						end
						default: ;
					endcase
				end
				S_WGT: begin
					cnt_q <= (cnt_q == 3'd6) ? 3'd0 : cnt_q + 3'd1;
					unique case (cnt_q)
						3'd1: begin
							acc_q <= ACW'(mul_p);
							old_q <= ram_rdata;
						end
						3'd3, 3'd5: acc_q <= ACW'(mul_p);
						3'd2: pend_q.weight_a <= wsat_c;
						3'd4: pend_q.weight_b <= wsat_c;
						3'd6: begin
							pend_q.weight_c <= wsat_c;
							state_q         <= S_DEPTH;
						end
						default: ;
					endcase
				end
				S_DEPTH: begin
					cnt_q <= (cnt_q == 3'd4) ? 3'd0 : cnt_q + 3'd1;
					unique case (cnt_q)
						3'd1: acc_q <= ACW'(mul_p);
						3'd2: acc_q <= acc_q + ACW'(mul_p);
						3'd3: pend_q.depth <= zsat_c;
						3'd4: begin
							pend_q.covered <= pass_c;
							state_q        <= S_OUT;
						end
						default: ;
					endcase
				end
				S_OUT: begin
					if (out_load) begin
						rsp_q   <= pend_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
